// ----- rtl/core/utf8dw_pkg.sv -----
// Shared types and constants for the UTF-8 display width counter.
package utf8dw_pkg;

   localparam int COUNT_BITS = 16;
   localparam int CP_BITS    = 21;
   localparam int WIDTH_BITS = 16;
   localparam int LEN_BITS   = 3;
   localparam int INCR_BITS  = 3;
   localparam int COL_BITS   = 2;

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [CP_BITS-1:0]    cp_type;
   typedef logic [LEN_BITS-1:0]   len_type;
   typedef logic [INCR_BITS-1:0]  incr_type;
   typedef logic [COL_BITS-1:0]   col_type;

   // Sequence lengths taken from the lead byte.
   localparam len_type SEQ_NONE = 3'd0;
   localparam len_type SEQ_LEN1 = 3'd1;
   localparam len_type SEQ_LEN2 = 3'd2;
   localparam len_type SEQ_LEN3 = 3'd3;
   localparam len_type SEQ_LEN4 = 3'd4;

   // Column widths a finished codepoint can take.
   localparam col_type COL_ZERO = 2'd0;
   localparam col_type COL_ONE  = 2'd1;
   localparam col_type COL_TWO  = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [WIDTH_BITS-1:0] total_width;
      logic                  width_saturated;
   } rsp_type;

   typedef struct packed {
      cp_type lo;
      cp_type hi;
   } span_type;

   localparam int ZERO_SPAN_COUNT   = 4;
   localparam int ARABIC_SPAN_COUNT = 6;

   // Zero-width direction controls.
   localparam span_type ZERO_SPANS [ZERO_SPAN_COUNT] = '{
      '{lo: 21'h0061C, hi: 21'h0061C},
      '{lo: 21'h0200B, hi: 21'h0200F},
      '{lo: 21'h0202A, hi: 21'h0202E},
      '{lo: 21'h02066, hi: 21'h02069}
   };

   // Arabic blocks and presentation forms, one column each unless listed as zero-width.
   localparam span_type ARABIC_SPANS [ARABIC_SPAN_COUNT] = '{
      '{lo: 21'h00600, hi: 21'h006FF},
      '{lo: 21'h00750, hi: 21'h0077F},
      '{lo: 21'h00870, hi: 21'h0089F},
      '{lo: 21'h008A0, hi: 21'h008FF},
      '{lo: 21'h0FB50, hi: 21'h0FDFF},
      '{lo: 21'h0FE70, hi: 21'h0FEFF}
   };

endpackage

// ----- rtl/core/utf8_display_width_counter_core.sv -----
// Top level of the UTF-8 display width counter.
// One byte of a UTF-8 string is taken per transaction on the req_ channel, with
// last_byte marking the end of the string; one transaction leaves on the rsp_
// channel per string, carrying its terminal column width and a saturation flag.
// Bytes are accepted back to back, one per clock: a byte is captured in an input
// register, and from there the decoder and the saturating column adder update
// their state from it in a single pass. The result of a string is loaded into
// the output register when its last byte moves on from the input register. The
// input only pauses while a finished result waits in the output register and the
// next string's last byte is already held behind it.
module utf8_display_width_counter_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  utf8dw_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output utf8dw_pkg::rsp_type rsp_data
);
   import utf8dw_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_item_ff;
   rsp_type step_result;
   logic    out_free;
   logic    step_go;

   assign out_free  = !out_valid_ff || rsp_ready;
   // The held byte moves on unless it ends a string and the result slot is busy.
   assign step_go   = in_valid_ff && (!in_item_ff.last_byte || out_free);
   assign req_ready = !in_valid_ff || step_go;

   utf8dw_decoder u_decoder (
      .clock       (clock),
      .reset       (reset),
      .step_valid  (step_go),
      .step_item   (in_item_ff),
      .step_result (step_result)
   );

   always_comb begin
      in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !step_go);
      out_valid_in = (step_go && in_item_ff.last_byte) || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
      if (step_go && in_item_ff.last_byte) begin
         out_item_ff <= step_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (step_go && in_item_ff.last_byte) |=> out_valid_ff)
      else $error("end of string did not load a result");

   a_stall_reason: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && in_item_ff.last_byte && out_valid_ff && !rsp_ready))
      else $error("input stalled without a blocked result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |-> !step_go || !in_item_ff.last_byte)
      else $error("pending result overwritten");

endmodule

// ----- rtl/core/utf8dw_classify.sv -----
// Column width of one decoded codepoint.
module utf8dw_classify (
   input  utf8dw_pkg::cp_type  codepoint,
   input  utf8dw_pkg::len_type seq_len,
   output utf8dw_pkg::col_type columns
);
   import utf8dw_pkg::*;

   logic [ZERO_SPAN_COUNT-1:0]   zero_hit;
   logic [ARABIC_SPAN_COUNT-1:0] arabic_hit;

   always_comb begin
      for (int i = 0; i < ZERO_SPAN_COUNT; i++) begin
         zero_hit[i] = (codepoint >= ZERO_SPANS[i].lo) && (codepoint <= ZERO_SPANS[i].hi);
      end
      for (int i = 0; i < ARABIC_SPAN_COUNT; i++) begin
         arabic_hit[i] = (codepoint >= ARABIC_SPANS[i].lo) &&
                         (codepoint <= ARABIC_SPANS[i].hi);
      end
   end

   always_comb begin
      priority if (|zero_hit) begin
         columns = COL_ZERO;
      end else if (|arabic_hit) begin
         columns = COL_ONE;
      end else if (seq_len >= SEQ_LEN3) begin
         columns = COL_TWO;
      end else begin
         columns = COL_ONE;
      end
   end

endmodule

// ----- rtl/core/utf8dw_decoder.sv -----
// Byte decoder state and saturating column count.
module utf8dw_decoder (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_valid,
   input  utf8dw_pkg::req_type step_item,
   output utf8dw_pkg::rsp_type step_result
);
   import utf8dw_pkg::*;

   count_type count_ff, count_in;
   logic      sat_ff, sat_in;
   len_type   expected_ff, expected_in;
   len_type   held_ff, held_in;
   cp_type    partial_ff, partial_in;

   logic [7:0] data;
   logic       is_cont;
   logic       do_fresh;
   len_type    held_inc;
   cp_type     cp_join;
   col_type    cp_columns;
   incr_type   incr;
   logic [COUNT_BITS:0] sum;
   logic       count_over;

   assign data     = step_item.data_byte;
   assign is_cont  = (data[7:6] == 2'b10);
   assign held_inc = held_ff + SEQ_LEN1;
   assign cp_join  = {partial_ff[CP_BITS-7:0], data[5:0]};

   utf8dw_classify u_classify (
      .codepoint (cp_join),
      .seq_len   (expected_ff),
      .columns   (cp_columns)
   );

   always_comb begin
      incr        = '0;
      expected_in = expected_ff;
      held_in     = held_ff;
      partial_in  = partial_ff;
      do_fresh    = 1'b0;

      if (expected_ff == SEQ_NONE) begin
         do_fresh = 1'b1;
      end else if (is_cont) begin
         if (held_inc >= expected_ff) begin
            expected_in = SEQ_NONE;
            held_in     = SEQ_NONE;
            partial_in  = '0;
            incr        = INCR_BITS'(cp_columns);
         end else begin
            held_in    = held_inc;
            partial_in = cp_join;
         end
      end else begin
         // A broken sequence costs one column per byte it held.
         incr        = INCR_BITS'(held_ff);
         expected_in = SEQ_NONE;
         held_in     = SEQ_NONE;
         partial_in  = '0;
         do_fresh    = 1'b1;
      end

      if (do_fresh) begin
         priority if (data[7] == 1'b0) begin
            incr = incr + INCR_BITS'(1);
         end else if (data[7:5] == 3'b110) begin
            expected_in = SEQ_LEN2;
            held_in     = SEQ_LEN1;
            partial_in  = cp_type'(data[4:0]);
         end else if (data[7:4] == 4'b1110) begin
            expected_in = SEQ_LEN3;
            held_in     = SEQ_LEN1;
            partial_in  = cp_type'(data[3:0]);
         end else if (data[7:3] == 5'b11110) begin
            expected_in = SEQ_LEN4;
            held_in     = SEQ_LEN1;
            partial_in  = cp_type'(data[2:0]);
         end else begin
            incr = incr + INCR_BITS'(1);
         end
      end

      // A sequence still open at the end of the string is charged per byte.
      if (step_item.last_byte && (expected_in != SEQ_NONE)) begin
         incr = incr + INCR_BITS'(held_in);
      end

      // One saturating add gives the same result as the successive ones.
      sum = {1'b0, count_ff} + (COUNT_BITS+1)'(incr);
      if (sum[COUNT_BITS]) begin
         count_in = '1;
         sat_in   = 1'b1;
      end else begin
         count_in = sum[COUNT_BITS-1:0];
         sat_in   = sat_ff;
      end
   end

   assign count_over = ((COUNT_BITS+1)'(count_in) > (COUNT_BITS+1)'(17'hFFFF));

   always_comb begin
      if (count_over) begin
         step_result.total_width     = '1;
         step_result.width_saturated = 1'b1;
      end else begin
         step_result.total_width     = WIDTH_BITS'(count_in);
         step_result.width_saturated = sat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         sat_ff      <= 1'b0;
         expected_ff <= SEQ_NONE;
         held_ff     <= SEQ_NONE;
         partial_ff  <= '0;
      end else if (step_valid) begin
         if (step_item.last_byte) begin
            count_ff    <= '0;
            sat_ff      <= 1'b0;
            expected_ff <= SEQ_NONE;
            held_ff     <= SEQ_NONE;
            partial_ff  <= '0;
         end else begin
            count_ff    <= count_in;
            sat_ff      <= sat_in;
            expected_ff <= expected_in;
            held_ff     <= held_in;
            partial_ff  <= partial_in;
         end
      end
   end

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (expected_ff == SEQ_NONE) |-> ((held_ff == SEQ_NONE) && (partial_ff == '0)))
      else $error("held bytes with no sequence open");

   a_held_below_len: assert property (@(posedge clock) disable iff (reset)
      (expected_ff != SEQ_NONE) |-> ((held_ff >= SEQ_LEN1) && (held_ff < expected_ff)))
      else $error("held byte count out of range for open sequence");

   a_sat_pinned: assert property (@(posedge clock) disable iff (reset)
      sat_ff |-> (count_ff == '1))
      else $error("saturation flag set but count not at maximum");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (step_valid && step_item.last_byte) |=> ((count_ff == '0) && !sat_ff &&
                                               (expected_ff == SEQ_NONE)))
      else $error("state not cleared after end of string");

endmodule
